// File: sv/efd_pkg.sv
// ============================================================================
// efd_pkg
// Shared types and constants for the epoch seconds to FAT date/time converter.
// ============================================================================
package efd_pkg;

    localparam int DATA_W = 32;

    // divisors
    localparam logic [16:0] DAY_SECS  = 17'd86400;
    localparam logic [11:0] HOUR_SECS = 12'd3600;
    localparam logic [5:0]  MIN_SECS  = 6'd60;

    // reciprocals, rounded up: q = ((x >> pre) * RECIP) >> post, exact over range
    // day:  x >> 7, divide by 675, post shift 35
    // hour: x >> 4, divide by 225, post shift 21
    // min:  x >> 2, divide by 15,  post shift 14
    localparam logic [25:0] DAY_RECIP  = 26'd50903317;
    localparam logic [13:0] HOUR_RECIP = 14'd9321;
    localparam logic [10:0] MIN_RECIP  = 11'd1093;

    // year offsets from 1970
    localparam logic [7:0] FAT_BASE_OFF = 8'd10;   // 1980
    localparam logic [7:0] Y2100_OFF    = 8'd130;  // 2100, not leap
    localparam logic [7:0] GRP_LAST_OFF = 8'd124;  // last 4-year group start clear of 2100

    localparam logic [15:0] GRP_DAYS   = 16'd1461;
    localparam logic [8:0]  YEAR_DAYS  = 9'd365;
    localparam logic [8:0]  LEAP_DAYS  = 9'd366;
    localparam logic [3:0]  FEB_IDX    = 4'd1;
    localparam logic [4:0]  FEB_LEAP   = 5'd29;

    localparam logic [4:0] MONTH_DAYS [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    typedef enum logic [3:0] {
        S_IDLE,
        S_DDIV,
        S_DREM,
        S_HDIV,
        S_HREM,
        S_MDIV,
        S_MREM,
        S_YEAR,
        S_MONTH,
        S_OUT
    } t_state;

    typedef struct packed {
        logic     load;
        logic     day_div;
        logic     day_rem;
        logic     hour_div;
        logic     hour_rem;
        logic     min_div;
        logic     min_rem;
        logic     year_step;
        logic     month_step;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic year_done;
        logic month_done;
        logic out_free;
    } t_stat;

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        len = MONTH_DAYS[m];
        if (m == FEB_IDX && leap) begin
            len = FEB_LEAP;
        end
        return len;
    endfunction

endpackage

// File: sv/efd_ctrl.sv
// ============================================================================
// efd_ctrl
// Sequencer: day, hour and minute divisions, then year and month walks and the output load.
// ============================================================================
module efd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  efd_pkg::t_stat i_stat,
    output efd_pkg::t_cmd  o_cmd
);
    import efd_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DDIV;
                end
            end
            S_DDIV: begin
                o_cmd.day_div = 1'b1;
                n_state       = S_DREM;
            end
            S_DREM: begin
                o_cmd.day_rem = 1'b1;
                n_state       = S_HDIV;
            end
            S_HDIV: begin
                o_cmd.hour_div = 1'b1;
                n_state        = S_HREM;
            end
            S_HREM: begin
                o_cmd.hour_rem = 1'b1;
                n_state        = S_MDIV;
            end
            S_MDIV: begin
                o_cmd.min_div = 1'b1;
                n_state       = S_MREM;
            end
            S_MREM: begin
                o_cmd.min_rem = 1'b1;
                n_state       = S_YEAR;
            end
            S_YEAR: begin
                if (i_stat.year_done) begin
                    n_state = S_MONTH;
                end else begin
                    o_cmd.year_step = 1'b1;
                end
            end
            S_MONTH: begin
                if (i_stat.month_done) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.month_step = 1'b1;
                end
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: sv/efd_dpath.sv
// ============================================================================
// efd_dpath
// Reciprocal-multiply divisions, year/month counters and the output register.
// ============================================================================
module efd_dpath (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  efd_pkg::t_cmd              i_cmd,
    output efd_pkg::t_stat             o_stat,
    input  logic [efd_pkg::DATA_W-1:0] i_data,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [31:0]                o_data,
    output logic                       o_user
);
    import efd_pkg::*;

    logic [DATA_W-1:0] r_rem;
    logic [15:0]       r_days;
    logic [4:0]        r_hour;
    logic [5:0]        r_min;
    logic [7:0]        r_year;
    logic [3:0]        r_month;
    logic [31:0]       r_out_data;
    logic              r_out_user;
    logic              r_out_valid;

    logic [50:0]       day_prod;
    logic [32:0]       day_back;
    logic [26:0]       hour_prod;
    logic [16:0]       hour_back;
    logic [20:0]       min_prod;
    logic [11:0]       min_back;
    logic              leap;
    logic              grp_take;
    logic [8:0]        ylen;
    logic              year_ge;
    logic [4:0]        mlen;
    logic              month_ge;
    logic              early;
    logic [31:0]       res_data;

    // 86400 = 128 * 675, 3600 = 16 * 225, 60 = 4 * 15
    assign day_prod  = r_rem[31:7] * DAY_RECIP;
    assign day_back  = r_days * DAY_SECS;
    assign hour_prod = r_rem[16:4] * HOUR_RECIP;
    assign hour_back = r_hour * HOUR_SECS;
    assign min_prod  = r_rem[11:2] * MIN_RECIP;
    assign min_back  = r_min * MIN_SECS;

    // 1970 + off is leap when off mod 4 == 2, except 2100
    assign leap     = (r_year[1:0] == 2'd2) && (r_year != Y2100_OFF);
    // whole 4-year groups starting 1970 while clear of 2100
    assign grp_take = (r_year <= GRP_LAST_OFF) && (r_days >= GRP_DAYS);
    assign ylen     = leap ? LEAP_DAYS : YEAR_DAYS;
    assign year_ge  = r_days >= {7'd0, ylen};
    assign mlen     = month_len(r_month, leap);
    assign month_ge = r_days >= {11'd0, mlen};

    assign o_stat.year_done  = !grp_take && !year_ge;
    assign o_stat.month_done = !month_ge;
    assign o_stat.out_free   = !r_out_valid || i_ready;

    assign early = r_year < FAT_BASE_OFF;

    always_comb begin
        res_data        = '0;
        res_data[20:16] = r_hour;
        res_data[26:21] = r_min;
        res_data[31:27] = r_rem[5:1];
        if (!early) begin
            res_data[6:0]   = 7'(r_year - FAT_BASE_OFF);
            res_data[10:7]  = r_month + 4'd1;
            res_data[15:11] = r_days[4:0] + 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rem   <= i_data;
            r_year  <= '0;
            r_month <= '0;
        end
        if (i_cmd.day_div) begin
            r_days <= day_prod[50:35];
        end
        if (i_cmd.day_rem) begin
            r_rem <= r_rem - day_back[31:0];
        end
        if (i_cmd.hour_div) begin
            r_hour <= hour_prod[25:21];
        end
        if (i_cmd.hour_rem) begin
            r_rem <= r_rem - {15'd0, hour_back};
        end
        if (i_cmd.min_div) begin
            r_min <= min_prod[19:14];
        end
        if (i_cmd.min_rem) begin
            r_rem <= r_rem - {20'd0, min_back};
        end
        if (i_cmd.year_step) begin
            if (grp_take) begin
                r_days <= r_days - GRP_DAYS;
                r_year <= r_year + 8'd4;
            end else begin
                r_days <= r_days - {7'd0, ylen};
                r_year <= r_year + 8'd1;
            end
        end
        if (i_cmd.month_step) begin
            r_days  <= r_days - {11'd0, mlen};
            r_month <= r_month + 4'd1;
        end
        if (i_cmd.out_load) begin
            r_out_data <= res_data;
            r_out_user <= early;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;
    assign o_user  = r_out_user;

endmodule

// File: sv/epoch_seconds_to_fat_datetime.sv
// Sequence from input accept to result valid: reciprocal-multiply day, hour and
// minute divisions, a year walk in 4-year groups then single years, a month walk
// of up to 11 steps, then the output load, which waits while the result is not taken.
// One item at a time: a new item is accepted only once the previous result has been
// loaded into the output register. Synchronous active-low reset clears state and valid.
// ============================================================================
// epoch_seconds_to_fat_datetime
// Converts seconds since 1970 into FAT date and time fields.
// ============================================================================
module epoch_seconds_to_fat_datetime (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] epoch_seconds
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [6:0] year_since_1980, [10:7] month_number, [15:11] day_of_month,
    // [20:16] hour_of_day, [26:21] minute_of_hour, [31:27] half_seconds
    output logic [31:0] o_m_tdata,
    output logic        o_m_tuser    // [0] before_1980
);
    import efd_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    efd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    efd_dpath u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .i_data  (i_s_tdata),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_data  (o_m_tdata),
        .o_user  (o_m_tuser)
    );

endmodule

// File: dv/fat_datetime_checker.sv
// ----------------------------------------------------------------------------
// fat_datetime_checker
// Watches both stream channels of the epoch seconds to FAT date/time
// converter, works out the expected date/time fields of every accepted item
// and compares each returned item, field by field, with the oldest one.
// ----------------------------------------------------------------------------
module fat_datetime_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] epoch_seconds
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    // [6:0] year_since_1980, [10:7] month_number, [15:11] day_of_month,
    // [20:16] hour_of_day, [26:21] minute_of_hour, [31:27] half_seconds
    input  logic [31:0] i_m_tdata,
    input  logic        i_m_tuser,   // [0] before_1980
    output int          o_fail_count,
    output int          o_pending
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned SECS_IN_DAY  = 86400;
    localparam int unsigned SECS_IN_HOUR = 3600;
    localparam int unsigned SECS_IN_MIN  = 60;
    localparam int unsigned UNIX_YEAR    = 1970;
    localparam int unsigned FAT_YEAR     = 1980;

    localparam int unsigned DAYS_IN_MONTH [12] = '{
        31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31
    };

    typedef struct packed {
        logic [6:0] year_since_1980;
        logic [3:0] month_number;
        logic [4:0] day_of_month;
        logic [4:0] hour_of_day;
        logic [5:0] minute_of_hour;
        logic [4:0] half_seconds;
        logic       before_1980;
    } t_fat_stamp;

    t_fat_stamp expected_stamps[$];
    int         mismatches = 0;
    int         pending_count = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = pending_count;

    function automatic bit is_leap(input int unsigned year);
        return (year % 400 == 0) || ((year % 100 != 0) && (year % 4 == 0));
    endfunction

    function automatic t_fat_stamp fat_stamp_of(input logic [31:0] secs);
        t_fat_stamp  st;
        int unsigned days;
        int unsigned rem;
        int unsigned year;
        int unsigned month;
        int unsigned span;
        int unsigned hour;
        int unsigned minute;
        int unsigned second;
        days  = secs / SECS_IN_DAY;
        rem   = secs % SECS_IN_DAY;
        year  = UNIX_YEAR;
        month = 0;
        forever begin
            span = is_leap(year) ? 366 : 365;
            if (days < span) break;
            days -= span;
            year++;
        end
        while (month < 12) begin
            span = (month == 1 && is_leap(year)) ? 29 : DAYS_IN_MONTH[month];
            if (days < span) break;
            days -= span;
            month++;
        end
        hour   = rem / SECS_IN_HOUR;
        rem    = rem - hour * SECS_IN_HOUR;
        minute = rem / SECS_IN_MIN;
        second = rem - minute * SECS_IN_MIN;

        st = '0;
        st.before_1980 = (year < FAT_YEAR);
        if (!st.before_1980) begin
            st.year_since_1980 = 7'(year - FAT_YEAR);
            st.month_number    = 4'(month + 1);
            st.day_of_month    = 5'(days + 1);
        end
        st.hour_of_day    = 5'(hour);
        st.minute_of_hour = 6'(minute);
        st.half_seconds   = 5'(second / 2);
        return st;
    endfunction

    function automatic int field_differs(input string name, input int unsigned want,
                                         input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin
        t_fat_stamp want;
        int         errs;
        errs = 0;
        if (i_rst_n) begin
            if (i_m_tvalid && i_m_tready) begin
                if (expected_stamps.size() == 0) begin
                    $error("result item 0x%08h/%0b with no item outstanding",
                           i_m_tdata, i_m_tuser);
                    errs++;
                end else begin
                    want = expected_stamps.pop_front();
                    errs += field_differs("year_since_1980", want.year_since_1980,
                                          i_m_tdata[6:0]);
                    errs += field_differs("month_number", want.month_number,
                                          i_m_tdata[10:7]);
                    errs += field_differs("day_of_month", want.day_of_month,
                                          i_m_tdata[15:11]);
                    errs += field_differs("hour_of_day", want.hour_of_day,
                                          i_m_tdata[20:16]);
                    errs += field_differs("minute_of_hour", want.minute_of_hour,
                                          i_m_tdata[26:21]);
                    errs += field_differs("half_seconds", want.half_seconds,
                                          i_m_tdata[31:27]);
                    errs += field_differs("before_1980", want.before_1980, i_m_tuser);
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                expected_stamps.push_back(fat_stamp_of(i_s_tdata));
            end
            mismatches    <= mismatches + errs;
            pending_count <= expected_stamps.size();
        end
    end

endmodule

// File: dv/epoch_seconds_to_fat_datetime_tb.sv
// ----------------------------------------------------------------------------
// epoch_seconds_to_fat_datetime_tb
// Drives epoch second counts into the converter: a directed set of calendar
// edges (pre-1980, leap days, century years, largest input), then random
// counts biased to day, year and range edges, with random stalls on both
// sides. The checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module epoch_seconds_to_fat_datetime_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1400;
    localparam int IDLE_LIMIT   = 2000;   // cycles with no item accepted or returned
    localparam int DRAIN_CYCLES = 100;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;

    int fail_count;
    int pending;
    bit s_no_gap = 1'b0;
    bit m_no_gap = 1'b0;

    epoch_seconds_to_fat_datetime dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    fat_datetime_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // one item: optional gap, then hold valid until accepted
    task automatic send_seconds(input logic [31:0] secs);
        int gap;
        gap = s_no_gap ? 0 : $urandom_range(0, 9);
        @(negedge clk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= secs;
        do @(posedge clk); while (!s_tready);
    endtask

    function automatic logic [31:0] pick_seconds();
        logic [31:0] day;
        logic [31:0] tod;
        case ($urandom_range(0, 9))
            0, 1, 2: return $urandom();
            3, 4, 5, 6: begin
                // whole days plus a time of day, mostly at or near midnight
                day = $urandom_range(0, 49709);
                case ($urandom_range(0, 3))
                    0: tod = 0;
                    1: tod = 86399;
                    2: tod = $urandom_range(0, 3);
                    default: tod = $urandom_range(0, 86399);
                endcase
                return day * 32'd86400 + tod;
            end
            7: return $urandom_range(0, 315532799);
            8: return $urandom_range(315532600, 315533000);
            default: return 32'hFFFF_FFFF - $urandom_range(0, 200000);
        endcase
    endfunction

    logic [31:0] edge_seconds [] = '{
        32'd0, 32'd1, 32'd59, 32'd86399, 32'd86400,
        32'd68255999,     // 1972-02-29 23:59:59, leap day before 1980
        32'd315532799,    // last second of 1979
        32'd315532800,    // 1980-01-01
        32'd320630400,    // 1980-02-29
        32'd320716800,    // 1980-03-01
        32'd946684799, 32'd946684800,   // turn of 2000
        32'd951782400,    // 2000-02-29, century leap year
        32'd951868800,    // 2000-03-01
        32'd4007836799,   // 2096-12-31 23:59:59, day 366
        32'd4007836800,
        32'd4102444799, 32'd4102444800, // turn of 2100
        32'd4107456000,   // 2100-02-28, century non-leap
        32'd4107542400,   // 2100-03-01
        32'h7FFF_FFFF, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA,
        32'hFFFF_FFFF
    };

    // stimulus and verdict
    initial begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (edge_seconds[i]) send_seconds(edge_seconds[i]);

        // let the directed items drain before the random part
        @(negedge clk);
        s_tvalid <= 1'b0;
        wait (pending == 0);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 100 == 0) begin
                s_no_gap = ($urandom_range(0, 3) == 0);
                m_no_gap = ($urandom_range(0, 3) == 0);
            end
            if (i % 250 == 125) begin
                // drop valid so the held item is not taken again while draining
                @(negedge clk);
                s_tvalid <= 1'b0;
                wait (pending == 0);
            end
            send_seconds(pick_seconds());
        end
        @(negedge clk);
        s_tvalid <= 1'b0;

        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // result side: random stall before each item
    initial begin
        int gap;
        @(posedge rst_n);
        forever begin
            gap = m_no_gap ? 0 : $urandom_range(0, 9);
            @(negedge clk);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    initial begin
        int idle;
        idle = 0;
        forever begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n) begin
                idle = 0;
            end else begin
                idle++;
            end
            if (idle == IDLE_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

endmodule
